FILE: design/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

   parameter int MAX_SLOTS  = 1024;
   parameter int SLOT_W     = $clog2(MAX_SLOTS);
   parameter int COUNT_W    = $clog2(MAX_SLOTS + 1);
   parameter int CSR_ADDR_W = 2;
   parameter int CSR_DATA_W = 32;

   parameter logic [COUNT_W-1:0]    CAP_MAX           = COUNT_W'(MAX_SLOTS);
   parameter logic [CSR_ADDR_W-1:0] CSR_ADDR_CAPACITY = CSR_ADDR_W'(0);

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_FULL        = 2'd1,
      STATUS_NOT_IN_POOL = 2'd2,
      STATUS_GUARD       = 2'd3
   } status_type;

   typedef struct packed {
      command_type        command;
      logic [COUNT_W-1:0] slot_to_free;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot_index;
      status_type         status;
      logic [COUNT_W-1:0] in_use_count;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic read;
      logic exec;
      logic cfg_write;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

FILE: design/fbpa_ctrl.sv
`default_nettype none

module fbpa_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [fbpa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   output fbpa_pkg::ctrl_cmd_type                cmd
);
   import fbpa_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      READ,
      EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.accept    = (state_ff == IDLE) && req_valid;
      cmd.read      = (state_ff == READ);
      cmd.exec      = (state_ff == EXEC) && (!rsp_valid_ff || rsp_ready);
      cmd.cfg_write = csr_psel && csr_penable && csr_pwrite &&
                      (csr_paddr == CSR_ADDR_CAPACITY);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) state_in = READ;
         end
         READ: begin
            state_in = EXEC;
         end
         EXEC: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: design/fbpa_datapath.sv
`default_nettype none

module fbpa_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire fbpa_pkg::ctrl_cmd_type           cmd,
   input  wire fbpa_pkg::req_type                req_data,
   input  wire logic [fbpa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output fbpa_pkg::rsp_type                     rsp_data,
   output logic [fbpa_pkg::COUNT_W-1:0]          capacity
);
   import fbpa_pkg::*;

   // pool bookkeeping
   logic [COUNT_W-1:0] cap_ff;
   logic [SLOT_W-1:0]  head_ff, head_in;
   logic               nonempty_ff, nonempty_in;
   logic [COUNT_W-1:0] fresh_ff, fresh_in;
   logic [COUNT_W-1:0] used_ff, used_in;

   // request being worked on
   command_type        cmd_ff;
   logic [COUNT_W-1:0] slot_ff;

   logic [SLOT_W-1:0]  link_mem [MAX_SLOTS];
   logic               taken_mem [MAX_SLOTS];
   logic [SLOT_W-1:0]  addr_ff, rd_addr_in;
   logic [SLOT_W-1:0]  link_rd_ff;
   logic               taken_rd_ff;

   rsp_type            rsp_ff, rsp_in;

   logic [COUNT_W-1:0] cap_eff;
   logic               taken_eff;
   logic               link_we;
   logic               taken_we;
   logic               taken_wdata;

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = COUNT_W'(1);
      end else if (cap_ff > CAP_MAX) begin
         cap_eff = CAP_MAX;
      end else begin
         cap_eff = cap_ff;
      end
   end

   // Frees read the returned slot, allocates read the list head or the fresh slot.
   always_comb begin
      if (cmd_ff == CMD_FREE) begin
         rd_addr_in = slot_ff[SLOT_W-1:0];
      end else if (nonempty_ff) begin
         rd_addr_in = head_ff;
      end else begin
         rd_addr_in = fresh_ff[SLOT_W-1:0];
      end
   end

   // Slots at or above the high-water mark have not been handed out since the
   // last clear, so their taken bit is stale and reads as zero.
   assign taken_eff = (COUNT_W'(addr_ff) < fresh_ff) && taken_rd_ff;

   always_comb begin
      head_in     = head_ff;
      nonempty_in = nonempty_ff;
      fresh_in    = fresh_ff;
      used_in     = used_ff;
      link_we     = 1'b0;
      taken_we    = 1'b0;
      taken_wdata = 1'b0;
      rsp_in.slot_index = '0;
      rsp_in.status     = STATUS_OK;

      if (cmd_ff == CMD_ALLOC) begin
         if (used_ff >= cap_eff) begin
            rsp_in.status = STATUS_FULL;
         end else if (nonempty_ff) begin
            if (taken_eff) begin
               rsp_in.status = STATUS_GUARD;
            end else begin
               head_in     = link_rd_ff;
               nonempty_in = fresh_ff > (used_ff + COUNT_W'(1));
               used_in     = used_ff + COUNT_W'(1);
               taken_we    = 1'b1;
               taken_wdata = 1'b1;
               rsp_in.slot_index = addr_ff;
            end
         end else begin
            if (fresh_ff >= cap_eff || taken_eff) begin
               rsp_in.status = STATUS_GUARD;
            end else begin
               fresh_in    = fresh_ff + COUNT_W'(1);
               used_in     = used_ff + COUNT_W'(1);
               taken_we    = 1'b1;
               taken_wdata = 1'b1;
               rsp_in.slot_index = addr_ff;
            end
         end
      end else begin
         if (slot_ff >= cap_eff) begin
            rsp_in.status = STATUS_NOT_IN_POOL;
         end else if (!taken_eff || used_ff == '0) begin
            rsp_in.status = STATUS_GUARD;
         end else begin
            head_in     = addr_ff;
            nonempty_in = 1'b1;
            used_in     = used_ff - COUNT_W'(1);
            link_we     = 1'b1;
            taken_we    = 1'b1;
            taken_wdata = 1'b0;
         end
      end

      rsp_in.in_use_count = used_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff      <= CAP_MAX;
         head_ff     <= '0;
         nonempty_ff <= 1'b0;
         fresh_ff    <= '0;
         used_ff     <= '0;
      end else if (cmd.cfg_write) begin
         cap_ff      <= csr_pwdata[COUNT_W-1:0];
         head_ff     <= '0;
         nonempty_ff <= 1'b0;
         fresh_ff    <= '0;
         used_ff     <= '0;
      end else if (cmd.exec) begin
         head_ff     <= head_in;
         nonempty_ff <= nonempty_in;
         fresh_ff    <= fresh_in;
         used_ff     <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff  <= req_data.command;
         slot_ff <= req_data.slot_to_free;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         addr_ff     <= rd_addr_in;
         link_rd_ff  <= link_mem[rd_addr_in];
         taken_rd_ff <= taken_mem[rd_addr_in];
      end
      if (cmd.exec && link_we) begin
         link_mem[addr_ff] <= head_ff;
      end
      if (cmd.exec && taken_we) begin
         taken_mem[addr_ff] <= taken_wdata;
      end
   end

   assign rsp_data = rsp_ff;
   assign capacity = cap_ff;

endmodule

`default_nettype wire

FILE: design/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator: hands out and takes back slot indexes of a
// pool of up to 1024 slots. Allocate returns the most recently freed slot, or
// the lowest never-used one; free returns a slot to the LIFO list. Each
// request beat gives one response beat with a status (ok, pool full, not in
// pool, guard error). One request is in flight at a time, so the block takes
// a new request only after the last one is through its steps: accept, a
// registered read of the link and taken-mark memories, then an update of the
// pool that loads the output register, which waits while that register is
// still full. A finished response waits in the output register while the next
// request is accepted. No clearing pass runs after reset or a capacity write:
// the high-water mark tells which taken marks are current. Writing the
// capacity register (address 0) returns the pool to all free; write it only
// while no request is outstanding.
`default_nettype none

module fixed_block_pool_allocator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire fbpa_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output fbpa_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [fbpa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [fbpa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [fbpa_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import fbpa_pkg::*;

   ctrl_cmd_type       cmd;
   logic [COUNT_W-1:0] capacity;

   fbpa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .cmd         (cmd)
   );

   fbpa_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .csr_pwdata (csr_pwdata),
      .rsp_data   (rsp_data),
      .capacity   (capacity)
   );

   assign csr_prdata = (csr_paddr == CSR_ADDR_CAPACITY) ? CSR_DATA_W'(capacity) : '0;
   assign csr_pready = 1'b1;

endmodule

`default_nettype wire

FILE: design/fbpa_checker.sv
`default_nettype none

module fbpa_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire fbpa_pkg::rsp_type  rsp_data
);
   import fbpa_pkg::*;

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // one request in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   // a fresh response follows an earlier accepted request
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
      else $error("response without matching request");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.in_use_count <= CAP_MAX)
      else $error("in-use count above pool size");

   a_no_grant_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.slot_index == '0)
      else $error("slot index given with error status");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: dv/tb_top.sv
`default_nettype none

module tb_top;
   import fbpa_pkg::*;

   localparam int GEN = 0;          // pool copy used while building stimulus
   localparam int CHK = 1;          // pool copy advanced on accepted beats
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 6;

   localparam int IDLE_NONE = 0;
   localparam int IDLE_SEND = 1;
   localparam int IDLE_RECV = 2;
   localparam int IDLE_BOTH = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   fixed_block_pool_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // two copies of the pool bookkeeping
   logic [SLOT_W-1:0] link_mem [2][MAX_SLOTS];
   bit                taken_mem [2][MAX_SLOTS];
   int unsigned       head_slot [2];
   bit                list_live [2];
   int unsigned       fresh_hwm [2];
   int unsigned       in_use [2];
   logic [10:0]       cap_reg [2];

   req_type     req_backlog [$];
   rsp_type     rsp_predicted [$];
   int unsigned held_slots [$];
   int unsigned last_freed;

   int  idle_mode = IDLE_NONE;
   bit  hold_arm = 1'b0;
   bit  hold_used = 1'b0;
   int  hold_left = 0;
   int  quiet_cycles = 0;
   int  err_count = 0;

   function automatic void pool_clear(input int c);
      for (int i = 0; i < MAX_SLOTS; i++) begin
         taken_mem[c][i] = 1'b0;
         link_mem[c][i] = '0;
      end
      head_slot[c] = 0;
      list_live[c] = 1'b0;
      fresh_hwm[c] = 0;
      in_use[c] = 0;
   endfunction

   function automatic rsp_type pool_apply(input int c, input req_type r);
      int unsigned cap;
      int unsigned s;
      rsp_type o;
      cap = cap_reg[c];
      if (cap < 1) cap = 1;
      if (cap > MAX_SLOTS) cap = MAX_SLOTS;
      o.slot_index = '0;
      o.status = STATUS_OK;
      if (r.command == CMD_ALLOC) begin
         if (in_use[c] >= cap) begin
            o.status = STATUS_FULL;
         end else if (list_live[c]) begin
            s = head_slot[c];
            if (taken_mem[c][s]) begin
               o.status = STATUS_GUARD;
            end else begin
               head_slot[c] = link_mem[c][s];
               list_live[c] = fresh_hwm[c] > in_use[c] + 1;
               taken_mem[c][s] = 1'b1;
               in_use[c]++;
               o.slot_index = SLOT_W'(s);
            end
         end else begin
            s = fresh_hwm[c];
            if (s >= cap || taken_mem[c][s]) begin
               o.status = STATUS_GUARD;
            end else begin
               taken_mem[c][s] = 1'b1;
               fresh_hwm[c]++;
               in_use[c]++;
               o.slot_index = SLOT_W'(s);
            end
         end
      end else begin
         s = r.slot_to_free;
         if (s >= cap) begin
            o.status = STATUS_NOT_IN_POOL;
         end else if (!taken_mem[c][s] || in_use[c] == 0) begin
            o.status = STATUS_GUARD;
         end else begin
            link_mem[c][s] = SLOT_W'(head_slot[c]);
            head_slot[c] = s;
            list_live[c] = 1'b1;
            taken_mem[c][s] = 1'b0;
            in_use[c]--;
         end
      end
      o.in_use_count = COUNT_W'(in_use[c]);
      return o;
   endfunction

   function automatic bit sender_idle();
      case (idle_mode)
         IDLE_SEND: return $urandom_range(99) < 82;
         IDLE_BOTH: return $urandom_range(99) < 25;
         default:   return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stall();
      case (idle_mode)
         IDLE_RECV: return $urandom_range(99) < 82;
         IDLE_BOTH: return $urandom_range(99) < 25;
         default:   return 1'b0;
      endcase
   endfunction

   task automatic report(input string what, input int got, input int want);
      if (err_count < 200)
         $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      err_count++;
   endtask

   // builds one request, tracks which slots the stimulus holds
   task automatic queue_req(input command_type cmd, input int unsigned slot);
      req_type r;
      rsp_type o;
      r.command = cmd;
      r.slot_to_free = COUNT_W'(slot);
      o = pool_apply(GEN, r);
      if (o.status == STATUS_OK) begin
         if (cmd == CMD_ALLOC) begin
            held_slots.push_back(o.slot_index);
         end else begin
            last_freed = slot;
            for (int i = 0; i < held_slots.size(); i++)
               if (held_slots[i] == slot) begin
                  held_slots.delete(i);
                  break;
               end
         end
      end
      req_backlog.push_back(r);
   endtask

   task automatic queue_random(input int n, input int alloc_pct);
      int unsigned pick;
      int unsigned cap;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         cap = (cap_reg[GEN] < 1) ? 1 : (cap_reg[GEN] > MAX_SLOTS) ? MAX_SLOTS : cap_reg[GEN];
         if (pick < alloc_pct) begin
            queue_req(CMD_ALLOC, $urandom_range(2047));
         end else if (pick < 90 && held_slots.size() > 0) begin
            queue_req(CMD_FREE, held_slots[$urandom_range(held_slots.size() - 1)]);
         end else begin
            case ($urandom_range(2))
               0: queue_req(CMD_FREE, $urandom_range(2047));
               1: queue_req(CMD_FREE, last_freed);
               default: queue_req(CMD_FREE, $urandom_range(cap - 1));
            endcase
         end
      end
   endtask

   task automatic wait_drained();
      while (req_backlog.size() > 0 || req_valid || rsp_predicted.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [10:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_CAPACITY;
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cap_reg[CHK] = value;
      pool_clear(CHK);
      @(negedge clock);
      cap_reg[GEN] = value;
      pool_clear(GEN);
      held_slots.delete();
      last_freed = 0;
   endtask

   task automatic run_phase(input logic [10:0] cap, input int mode, input int n,
                            input int alloc_pct);
      write_capacity(cap);
      idle_mode = mode;
      queue_random(n, alloc_pct);
      wait_drained();
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_backlog.size() > 0 && !sender_idle()) begin
            req_valid <= 1'b1;
            req_data <= req_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response sink, with one long hold-off when armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_used) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else begin
         rsp_ready <= !receiver_stall();
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            rsp_predicted.push_back(pool_apply(CHK, req_data));
         if (rsp_valid && rsp_ready) begin
            if (rsp_predicted.size() == 0) begin
               report("unexpected response beat", 0, 0);
            end else begin
               want = rsp_predicted.pop_front();
               if (rsp_data.slot_index !== want.slot_index)
                  report("slot_index", rsp_data.slot_index, want.slot_index);
               if (rsp_data.status !== want.status)
                  report("status", rsp_data.status, want.status);
               if (rsp_data.in_use_count !== want.in_use_count)
                  report("in_use_count", rsp_data.in_use_count, want.in_use_count);
            end
         end
      end
   end

   // watchdog on stalled progress
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (req_backlog.size() > 0 || req_valid || rsp_predicted.size() > 0) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      cap_reg[GEN] = 11'd1024;
      cap_reg[CHK] = 11'd1024;
      pool_clear(GEN);
      pool_clear(CHK);
      last_freed = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset capacity: guard, LIFO reuse, bounds at 1024
      queue_req(CMD_FREE, 0);
      queue_req(CMD_ALLOC, 2047);
      queue_req(CMD_ALLOC, 0);
      queue_req(CMD_ALLOC, 0);
      queue_req(CMD_FREE, 1);
      queue_req(CMD_FREE, 1);
      queue_req(CMD_ALLOC, 0);
      queue_req(CMD_FREE, 2047);
      queue_req(CMD_FREE, 1024);
      queue_req(CMD_FREE, 1023);
      queue_req(CMD_FREE, 0);
      queue_req(CMD_FREE, 2);
      queue_req(CMD_ALLOC, 0);
      queue_req(CMD_ALLOC, 0);
      queue_req(CMD_ALLOC, 0);
      wait_drained();

      // capacity zero saturates to one slot
      write_capacity(11'd0);
      queue_req(CMD_ALLOC, 0);
      queue_req(CMD_ALLOC, 0);
      queue_req(CMD_FREE, 1);
      queue_req(CMD_FREE, 0);
      queue_req(CMD_FREE, 0);
      queue_req(CMD_ALLOC, 1024);
      wait_drained();

      run_phase(11'd3, IDLE_NONE, 60, 50);
      run_phase(11'd16, IDLE_SEND, 100, 55);
      run_phase(11'd1, IDLE_RECV, 50, 50);
      run_phase(11'd40, IDLE_BOTH, 110, 55);

      // long sink hold-off while the source keeps offering
      write_capacity(11'd1024);
      idle_mode = IDLE_NONE;
      hold_arm = 1'b1;
      queue_random(110, 60);
      wait_drained();
      hold_arm = 1'b0;

      run_phase(11'd2, IDLE_BOTH, 60, 50);
      run_phase(11'd300, IDLE_SEND, 70, 60);
      run_phase(11'd2047, IDLE_RECV, 140, 90);
      run_phase(11'd7, IDLE_NONE, 50, 50);

      wait_drained();
      if (err_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
design/fbpa_pkg.sv
design/fbpa_ctrl.sv
design/fbpa_datapath.sv
design/fixed_block_pool_allocator.sv
design/fbpa_checker.sv
dv/tb_top.sv
